/* rtl/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// ssp_pkg
// Types, sizes and codes for the single-source shortest path block.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

   localparam int MAX_NODES  = 64;
   localparam int MAX_EDGES  = 1024;

   localparam int NODE_W     = 6;
   localparam int NODE_CNT_W = 7;
   localparam int WEIGHT_W   = 16;
   localparam int DIST_W     = 40;
   localparam int CSR_W      = 7;

   localparam int EDGE_AW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EDGE_CW    = $clog2(MAX_EDGES + 1);

   // register indexes on the csr port
   localparam logic CSR_NODE_COUNT  = 1'b0;
   localparam logic CSR_SOURCE_NODE = 1'b1;

   typedef struct packed {
      logic [NODE_W-1:0]          tail;
      logic [NODE_W-1:0]          head;
      logic signed [WEIGHT_W-1:0] weight;
   } edge_type;

   localparam int EDGE_BITS = $bits(edge_type);

   typedef struct packed {
      logic                     relax;
      logic signed [DIST_W-1:0] cand;
   } relax_res_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_INIT   = 6'b000010,
      ST_FETCH  = 6'b000100,
      ST_LOOKUP = 6'b001000,
      ST_RELAX  = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

endpackage

`default_nettype wire

/* rtl/ssp_ram.sv */
// ----------------------------------------------------------------------------
// ssp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/ssp_relax.sv */
// ----------------------------------------------------------------------------
// ssp_relax
// Shared relaxation unit: saturating add of tail distance and edge weight,
// then compare against the head distance.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_relax
   import ssp_pkg::*;
(
   input  wire logic                       tail_ok,
   input  wire logic                       head_ok,
   input  wire logic                       tail_reached,
   input  wire logic                       head_reached,
   input  wire logic signed [DIST_W-1:0]   tail_dist,
   input  wire logic signed [DIST_W-1:0]   head_dist,
   input  wire logic signed [WEIGHT_W-1:0] weight,
   output relax_res_type                   res
);

   logic signed [DIST_W:0]   sum;
   logic signed [DIST_W-1:0] cand;

   always_comb begin
      sum = {tail_dist[DIST_W-1], tail_dist}
          + {{(DIST_W + 1 - WEIGHT_W){weight[WEIGHT_W-1]}}, weight};
      // clamp to the 40-bit signed range on overflow
      if (sum[DIST_W] != sum[DIST_W-1]) begin
         cand = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
      end else begin
         cand = sum[DIST_W-1:0];
      end
      res.cand  = cand;
      res.relax = tail_ok && head_ok && tail_reached
               && (!head_reached || (cand < head_dist));
   end

endmodule

`default_nettype wire

/* rtl/single_source_shortest_path.sv */
// ----------------------------------------------------------------------------
// single_source_shortest_path
// Bellman-Ford shortest paths over a loaded list of directed weighted edges.
// ----------------------------------------------------------------------------
// An edge beat is taken whenever start is high and busy is low. The edge
// marked last_edge starts a run: a setup state, then node_count passes
// (node_count-1 relaxing, one check) over E stored edges, each edge going
// through the fetch, lookup and relax states (edge read, distance read,
// relax and write through the one shared add/compare unit); the check pass
// stops at the first edge that still relaxes. Then node_count result beats
// follow, one per cycle through the read registers, each shown on the rsp_
// ports for exactly one cycle with rsp_valid high. The receiver cannot
// stall. Busy falls while the last results drain, and new edges may be
// loaded then.
// ----------------------------------------------------------------------------
`default_nettype none

module single_source_shortest_path
   import ssp_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [NODE_W-1:0]          req_edge_from,
   input  wire logic [NODE_W-1:0]          req_edge_to,
   input  wire logic signed [WEIGHT_W-1:0] req_edge_weight,
   input  wire logic                       req_last_edge,
   input  wire logic                       csr_write,
   input  wire logic                       csr_index,
   input  wire logic [CSR_W-1:0]           csr_wdata,
   output logic                            rsp_valid,
   output logic [NODE_W-1:0]               rsp_node_index,
   output logic signed [DIST_W-1:0]        rsp_distance,
   output logic                            rsp_reachable,
   output logic                            rsp_negative_cycle,
   output logic                            rsp_last_node
);

   state_type state_ff, state_in;

   logic [NODE_CNT_W-1:0] node_count_ff;
   logic [NODE_W-1:0]     source_node_ff;

   logic [EDGE_CW-1:0]    edge_total_ff, edge_total_in;
   logic [EDGE_CW-1:0]    edge_idx_ff, edge_idx_in;
   logic [NODE_CNT_W-1:0] n_ff, n_in;
   logic [NODE_W-1:0]     src_ff, src_in;
   logic [NODE_CNT_W-1:0] pass_ff, pass_in;
   logic [NODE_W-1:0]     emit_idx_ff, emit_idx_in;
   logic [MAX_NODES-1:0]  reached_ff, reached_in;
   logic                  ncycle_ff, ncycle_in;
   edge_type              edge_ff;

   // read pipeline for result beats
   logic              rd_vld_ff;
   logic [NODE_W-1:0] rd_idx_ff;
   logic              rd_reach_ff;
   logic              rd_ncycle_ff;
   logic              rd_last_ff;

   logic                     accept;
   logic                     edge_wr;
   edge_type                 edge_wdata;
   logic [EDGE_BITS-1:0]     edge_q;
   edge_type                 edge_rd;
   logic [NODE_W-1:0]        dist_addr_a;
   logic signed [DIST_W-1:0] dist_q_a, dist_q_b;
   logic                     dist_wr;
   logic [NODE_W-1:0]        dist_wr_addr;
   logic signed [DIST_W-1:0] dist_wr_data;
   relax_res_type            relax_res;
   logic                     check_pass;
   logic                     last_in_pass;
   logic                     src_ok;
   logic [NODE_CNT_W-1:0]    n_clamp;

   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff != ST_IDLE);
   assign edge_wr    = accept && (edge_total_ff < EDGE_CW'(MAX_EDGES));
   assign edge_wdata = '{tail: req_edge_from, head: req_edge_to, weight: req_edge_weight};
   assign edge_rd    = edge_type'(edge_q);

   assign check_pass   = (pass_ff == (n_ff - NODE_CNT_W'(1)));
   assign last_in_pass = ((edge_idx_ff + EDGE_CW'(1)) == edge_total_ff);
   assign src_ok       = ({1'b0, src_ff} < n_ff);
   assign dist_addr_a  = (state_ff == ST_EMIT) ? emit_idx_ff : edge_rd.tail;
   // setup writes the source distance of zero; relax writes improved heads
   assign dist_wr      = ((state_ff == ST_INIT) && src_ok)
                      || ((state_ff == ST_RELAX) && relax_res.relax && !check_pass);
   assign dist_wr_addr = (state_ff == ST_INIT) ? src_ff : edge_ff.head;
   assign dist_wr_data = (state_ff == ST_INIT) ? '0 : relax_res.cand;

   always_comb begin
      if (node_count_ff == '0) begin
         n_clamp = NODE_CNT_W'(1);
      end else if (node_count_ff > NODE_CNT_W'(MAX_NODES)) begin
         n_clamp = NODE_CNT_W'(MAX_NODES);
      end else begin
         n_clamp = node_count_ff;
      end
   end

   ssp_ram #(.WIDTH(EDGE_BITS), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr),
      .wr_addr (edge_total_ff[EDGE_AW-1:0]),
      .wr_data (edge_wdata),
      .rd_addr (edge_idx_ff[EDGE_AW-1:0]),
      .rd_data (edge_q)
   );

   // two copies of the distance store give tail and head reads in the same cycle
   ssp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_ram_a (
      .clock   (clock),
      .wr_en   (dist_wr),
      .wr_addr (dist_wr_addr),
      .wr_data (dist_wr_data),
      .rd_addr (dist_addr_a),
      .rd_data (dist_q_a)
   );

   ssp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_ram_b (
      .clock   (clock),
      .wr_en   (dist_wr),
      .wr_addr (dist_wr_addr),
      .wr_data (dist_wr_data),
      .rd_addr (edge_rd.head),
      .rd_data (dist_q_b)
   );

   ssp_relax u_relax (
      .tail_ok      ({1'b0, edge_ff.tail} < n_ff),
      .head_ok      ({1'b0, edge_ff.head} < n_ff),
      .tail_reached (reached_ff[edge_ff.tail]),
      .head_reached (reached_ff[edge_ff.head]),
      .tail_dist    (dist_q_a),
      .head_dist    (dist_q_b),
      .weight       (edge_ff.weight),
      .res          (relax_res)
   );

   always_comb begin
      state_in      = state_ff;
      edge_total_in = edge_total_ff;
      edge_idx_in   = edge_idx_ff;
      n_in          = n_ff;
      src_in        = src_ff;
      pass_in       = pass_ff;
      emit_idx_in   = emit_idx_ff;
      reached_in    = reached_ff;
      ncycle_in     = ncycle_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (edge_wr) begin
                  edge_total_in = edge_total_ff + EDGE_CW'(1);
               end
               if (req_last_edge) begin
                  n_in     = n_clamp;
                  src_in   = source_node_ff;
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            reached_in  = '0;
            ncycle_in   = 1'b0;
            pass_in     = '0;
            edge_idx_in = '0;
            emit_idx_in = '0;
            if (src_ok) begin
               reached_in[src_ff] = 1'b1;
            end
            state_in = (src_ok && (edge_total_ff != '0)) ? ST_FETCH : ST_EMIT;
         end
         ST_FETCH: begin
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_RELAX;
         end
         ST_RELAX: begin
            if (relax_res.relax && check_pass) begin
               // check pass: one relaxable edge is enough
               ncycle_in = 1'b1;
               state_in  = ST_EMIT;
            end else begin
               if (relax_res.relax) begin
                  reached_in[edge_ff.head] = 1'b1;
               end
               if (last_in_pass) begin
                  edge_idx_in = '0;
                  if (check_pass) begin
                     state_in = ST_EMIT;
                  end else begin
                     pass_in  = pass_ff + NODE_CNT_W'(1);
                     state_in = ST_FETCH;
                  end
               end else begin
                  edge_idx_in = edge_idx_ff + EDGE_CW'(1);
                  state_in    = ST_FETCH;
               end
            end
         end
         ST_EMIT: begin
            emit_idx_in = emit_idx_ff + NODE_W'(1);
            if ({1'b0, emit_idx_ff} == (n_ff - NODE_CNT_W'(1))) begin
               edge_total_in = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         edge_total_ff  <= '0;
         node_count_ff  <= NODE_CNT_W'(MAX_NODES);
         source_node_ff <= '0;
         rd_vld_ff      <= 1'b0;
         rsp_valid      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_total_ff <= edge_total_in;
         if (csr_write) begin
            case (csr_index)
               CSR_NODE_COUNT:  node_count_ff  <= csr_wdata[NODE_CNT_W-1:0];
               CSR_SOURCE_NODE: source_node_ff <= csr_wdata[NODE_W-1:0];
               default: ;
            endcase
         end
         rd_vld_ff <= (state_ff == ST_EMIT);
         rsp_valid <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      edge_idx_ff <= edge_idx_in;
      n_ff        <= n_in;
      src_ff      <= src_in;
      pass_ff     <= pass_in;
      emit_idx_ff <= emit_idx_in;
      reached_ff  <= reached_in;
      ncycle_ff   <= ncycle_in;
      if (state_ff == ST_LOOKUP) begin
         edge_ff <= edge_rd;
      end
      // capture per-beat status at read time so a following run cannot disturb it
      rd_idx_ff    <= emit_idx_ff;
      rd_reach_ff  <= reached_ff[emit_idx_ff];
      rd_ncycle_ff <= ncycle_ff;
      rd_last_ff   <= ({1'b0, emit_idx_ff} == (n_ff - NODE_CNT_W'(1)));
      rsp_node_index     <= rd_idx_ff;
      rsp_distance       <= rd_reach_ff ? dist_q_a : '0;
      rsp_reachable      <= rd_reach_ff;
      rsp_negative_cycle <= rd_ncycle_ff;
      rsp_last_node      <= rd_last_ff;
   end

endmodule

`default_nettype wire
